// ----- sv/jfdd_pkg.sv -----
// shared types and constants for the joystick frame differential drive unit
// no dependencies

package jfdd_pkg;

   localparam int BYTE_W      = 8;
   localparam int PARAM_COUNT = 5;
   localparam int POS_W       = 3;
   localparam int MIX_W       = 10;
   localparam int MAG_W       = 9;
   localparam int DUTY_W      = 16;

   // reciprocal scaling: 2**RECIP_SHIFT exceeds the square of the largest drive limit
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = DUTY_W + RECIP_SHIFT + 1;

   localparam logic [BYTE_W-1:0] START_BYTE  = 8'd255;
   localparam logic [BYTE_W-1:0] STOP_BYTE   = 8'd254;
   localparam logic [MIX_W-1:0]  AXIS_CENTRE = 10'd253;

   // frame position codes
   localparam logic [POS_W-1:0] POS_IDLE  = 3'd0;
   localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
   localparam logic [POS_W-1:0] POS_LAST  = 3'd5;
   localparam logic [POS_W-1:0] POS_CLOSE = 3'd6;

   typedef logic [PARAM_COUNT-1:0][BYTE_W-1:0] param_set_type;

   typedef struct packed {
      logic closing;   // next byte is the closing byte of a frame
      logic commit;    // accepted beat commits the frame
   } frame_status_type;

endpackage

// ----- sv/joystick_frame_differential_drive_unit.sv -----
// top level: frame receiver, two-sided drive mixer and result register
// depends on jfdd_pkg, jfdd_frame, jfdd_side
//
// result: registered; it appears in the cycle after the closing stop byte is taken
// throughput: one byte per cycle; req_stall rises only while a result is held
//   by rsp_stall and the next byte could close a frame
// reset: synchronous, clears the frame position and the result valid flag

module joystick_frame_differential_drive_unit #(
   parameter int PWM_TOP     = 1000,
   parameter int DRIVE_LIMIT = 253
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [jfdd_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [jfdd_pkg::BYTE_W-1:0]    rsp_param_one,
   output logic [jfdd_pkg::BYTE_W-1:0]    rsp_param_two,
   output logic [jfdd_pkg::BYTE_W-1:0]    rsp_param_three,
   output logic [jfdd_pkg::BYTE_W-1:0]    rsp_param_four,
   output logic [jfdd_pkg::BYTE_W-1:0]    rsp_param_five,
   output logic                           rsp_left_forward,
   output logic [jfdd_pkg::DUTY_W-1:0]    rsp_left_duty,
   output logic                           rsp_right_forward,
   output logic [jfdd_pkg::DUTY_W-1:0]    rsp_right_duty
);
   import jfdd_pkg::*;

   logic                    accept;
   frame_status_type        status;
   param_set_type           params;
   logic signed [MIX_W-1:0] left_mix;
   logic signed [MIX_W-1:0] right_mix;
   logic                    left_forward;
   logic                    right_forward;
   logic [DUTY_W-1:0]       left_duty;
   logic [DUTY_W-1:0]       right_duty;

   logic                    rsp_valid_ff;
   param_set_type           rsp_params_ff;
   logic                    rsp_left_forward_ff;
   logic                    rsp_right_forward_ff;
   logic [DUTY_W-1:0]       rsp_left_duty_ff;
   logic [DUTY_W-1:0]       rsp_right_duty_ff;

   // only a closing byte can need the result register
   assign req_stall = rsp_valid_ff && rsp_stall && status.closing;
   assign accept    = req_valid && !req_stall;

   jfdd_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .status  (status),
      .params  (params)
   );

   // left = p4 - p3, right = 253 - p3 - p4
   assign left_mix  = $signed({2'b00, params[3]}) - $signed({2'b00, params[2]});
   assign right_mix = $signed(AXIS_CENTRE) - $signed({2'b00, params[2]})
                      - $signed({2'b00, params[3]});

   jfdd_side #(.PWM_TOP(PWM_TOP), .DRIVE_LIMIT(DRIVE_LIMIT)) u_left (
      .mix     (left_mix),
      .forward (left_forward),
      .duty    (left_duty)
   );

   jfdd_side #(.PWM_TOP(PWM_TOP), .DRIVE_LIMIT(DRIVE_LIMIT)) u_right (
      .mix     (right_mix),
      .forward (right_forward),
      .duty    (right_duty)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (status.commit) begin
         rsp_params_ff        <= params;
         rsp_left_forward_ff  <= left_forward;
         rsp_left_duty_ff     <= left_duty;
         rsp_right_forward_ff <= right_forward;
         rsp_right_duty_ff    <= right_duty;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_param_one     = rsp_params_ff[0];
   assign rsp_param_two     = rsp_params_ff[1];
   assign rsp_param_three   = rsp_params_ff[2];
   assign rsp_param_four    = rsp_params_ff[3];
   assign rsp_param_five    = rsp_params_ff[4];
   assign rsp_left_forward  = rsp_left_forward_ff;
   assign rsp_left_duty     = rsp_left_duty_ff;
   assign rsp_right_forward = rsp_right_forward_ff;
   assign rsp_right_duty    = rsp_right_duty_ff;

`ifndef SYNTH
   a_commit_gives_beat: assert property (@(posedge clock) disable iff (reset)
      status.commit |=> rsp_valid_ff)
      else $error("committed frame did not produce a result beat");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      status.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("commit overwrote a held result");
   a_duty_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_left_duty_ff <= DUTY_W'(PWM_TOP)
                       && rsp_right_duty_ff <= DUTY_W'(PWM_TOP))
      else $error("duty above pwm top");
   a_result_params_match: assert property (@(posedge clock) disable iff (reset)
      status.commit |=> rsp_params_ff == $past(params))
      else $error("result parameters differ from the committed frame");
`endif

endmodule

// ----- sv/jfdd_frame.sv -----
// frame receiver: tracks the frame position and holds the pending parameters
// depends on jfdd_pkg

module jfdd_frame (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [jfdd_pkg::BYTE_W-1:0]   rx_byte,
   output jfdd_pkg::frame_status_type    status,
   output jfdd_pkg::param_set_type       params
);
   import jfdd_pkg::*;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   param_set_type    params_ff;

   always_comb begin
      case (pos_ff)
         3'd1, 3'd2, 3'd3, 3'd4, 3'd5: pos_in = pos_ff + POS_W'(1);
         POS_CLOSE:                    pos_in = POS_IDLE;
         default:                      pos_in = POS_IDLE;
      endcase
      // a start byte restarts the frame from any position
      if (rx_byte == START_BYTE) begin
         pos_in = POS_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_IDLE;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   for (genvar k = 0; k < PARAM_COUNT; k++) begin : g_param
      always_ff @(posedge clock) begin
         if (accept && pos_ff == POS_W'(k + 1)) begin
            params_ff[k] <= rx_byte;
         end
      end
   end

   assign status.closing = (pos_ff == POS_CLOSE);
   assign status.commit  = accept && (pos_ff == POS_CLOSE) && (rx_byte == STOP_BYTE);
   assign params         = params_ff;

`ifndef SYNTH
   a_param_slots_advance: assert property (@(posedge clock) disable iff (reset)
      accept && pos_ff >= POS_FIRST && pos_ff < POS_LAST && rx_byte != START_BYTE
      |=> pos_ff == $past(pos_ff) + POS_W'(1))
      else $error("frame position did not advance through parameter slots");
   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && rx_byte == START_BYTE |=> pos_ff == POS_FIRST)
      else $error("start byte did not restart the frame");
`endif

endmodule

// ----- sv/jfdd_side.sv -----
// drive of one motor side: direction bit and scaled, saturated pwm duty
// depends on jfdd_pkg

module jfdd_side #(
   parameter int PWM_TOP     = 1000,
   parameter int DRIVE_LIMIT = 253
) (
   input  logic signed [jfdd_pkg::MIX_W-1:0]  mix,
   output logic                               forward,
   output logic        [jfdd_pkg::DUTY_W-1:0] duty
);
   import jfdd_pkg::*;

   // ceiling of PWM_TOP * 2**RECIP_SHIFT / DRIVE_LIMIT makes the truncated quotient exact
   localparam longint unsigned RECIP =
      ((longint'(PWM_TOP) << RECIP_SHIFT) + longint'(DRIVE_LIMIT) - 1) / longint'(DRIVE_LIMIT);

   logic [MIX_W-1:0]         mix_abs;
   logic [MAG_W-1:0]         mag;
   logic [MAG_W+RECIP_W-1:0] product;
   logic                     saturate;

   assign forward  = !mix[MIX_W-1];
   assign mix_abs  = mix[MIX_W-1] ? (~mix + MIX_W'(1)) : mix;
   assign mag      = mix_abs[MAG_W-1:0];
   assign saturate = mix_abs >= MIX_W'(DRIVE_LIMIT);
   assign product  = {{RECIP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP_W'(RECIP)};
   assign duty     = saturate ? DUTY_W'(PWM_TOP) : product[RECIP_SHIFT +: DUTY_W];

endmodule

// ----- verif/joystick_frame_differential_drive_unit_tb.sv -----
// testbench for joystick_frame_differential_drive_unit: serial frame bytes in, drive results out
// depends on jfdd_pkg and the unit itself; results are checked against an in-bench predictor
// of the frame receiver and mixer

module joystick_frame_differential_drive_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import jfdd_pkg::*;

   localparam int PWM_TOP     = 1000;
   localparam int DRIVE_LIMIT = 253;
   localparam int FRAME_BYTES = 850;

   typedef struct packed {
      param_set_type          params;
      logic                   left_forward;
      logic [DUTY_W-1:0]      left_duty;
      logic                   right_forward;
      logic [DUTY_W-1:0]      right_duty;
   } drive_result_type;

   typedef struct {
      logic [BYTE_W-1:0] rx_byte;
      int                phase;
      bit                drain;
   } rx_beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_rx_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BYTE_W-1:0]   rsp_param_one;
   logic [BYTE_W-1:0]   rsp_param_two;
   logic [BYTE_W-1:0]   rsp_param_three;
   logic [BYTE_W-1:0]   rsp_param_four;
   logic [BYTE_W-1:0]   rsp_param_five;
   logic                rsp_left_forward;
   logic [DUTY_W-1:0]   rsp_left_duty;
   logic                rsp_right_forward;
   logic [DUTY_W-1:0]   rsp_right_duty;

   rx_beat_type         rx_beats[$];
   drive_result_type    pending_drives[$];
   logic [POS_W-1:0]    frame_pos;
   param_set_type       partial_params;
   int                  traffic_phase = 0;
   int                  mismatch_count = 0;
   int                  drives_seen = 0;
   int                  frame_bytes = 0;

   joystick_frame_differential_drive_unit #(
      .PWM_TOP     (PWM_TOP),
      .DRIVE_LIMIT (DRIVE_LIMIT)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_param_one     (rsp_param_one),
      .rsp_param_two     (rsp_param_two),
      .rsp_param_three   (rsp_param_three),
      .rsp_param_four    (rsp_param_four),
      .rsp_param_five    (rsp_param_five),
      .rsp_left_forward  (rsp_left_forward),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_forward (rsp_right_forward),
      .rsp_right_duty    (rsp_right_duty)
   );

   function automatic int sender_idle_pct(int phase);
      case (phase)
         0: return 14;
         1: return 74;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct(int phase);
      case (phase)
         0: return 74;
         1: return 14;
         default: return 0;
      endcase
   endfunction

   // direction bit on top, saturated duty below
   function automatic logic [DUTY_W:0] side_drive(int mix);
      int mag;
      int duty;
      mag = (mix < 0) ? -mix : mix;
      duty = (mag >= DRIVE_LIMIT) ? PWM_TOP : (mag * PWM_TOP) / DRIVE_LIMIT;
      return {mix >= 0, duty[DUTY_W-1:0]};
   endfunction

   task automatic take_rx_byte(logic [BYTE_W-1:0] b);
      drive_result_type  drv;
      int                fwd;
      logic [DUTY_W:0]   side;
      if (frame_pos >= POS_FIRST && frame_pos <= POS_LAST) begin
         partial_params[frame_pos - POS_FIRST] = b;
         frame_pos = frame_pos + 1'b1;
      end else if (frame_pos == POS_CLOSE) begin
         if (b == STOP_BYTE) begin
            drv.params = partial_params;
            // forward axis is inverted around the center value
            fwd = int'(AXIS_CENTRE) - int'(partial_params[2]);
            side = side_drive(fwd + int'(partial_params[3]) - int'(AXIS_CENTRE));
            {drv.left_forward, drv.left_duty} = side;
            side = side_drive(fwd - int'(partial_params[3]));
            {drv.right_forward, drv.right_duty} = side;
            pending_drives.push_back(drv);
         end
         frame_pos = POS_IDLE;
      end else begin
         frame_pos = POS_IDLE;
      end
      if (b == START_BYTE)
         frame_pos = POS_FIRST;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch, result %0d, %s: got %0d, expected %0d", drives_seen, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(string what, int got, int want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   task automatic push_byte(logic [BYTE_W-1:0] b, int phase);
      rx_beat_type beat;
      beat.rx_byte = b;
      beat.phase = phase;
      beat.drain = 1'b0;
      rx_beats.push_back(beat);
   endtask

   task automatic push_drain(int phase);
      rx_beat_type beat;
      beat.rx_byte = '0;
      beat.phase = phase;
      beat.drain = 1'b1;
      rx_beats.push_back(beat);
   endtask

   function automatic logic [BYTE_W-1:0] pick_param();
      logic [BYTE_W-1:0] corners[10];
      corners = '{8'd0, 8'd1, 8'd2, 8'd126, 8'd127, 8'd128, 8'd251, 8'd252, 8'd253, 8'd254};
      if ($urandom_range(99) < 3)
         return START_BYTE;
      if ($urandom_range(99) < 25)
         return corners[$urandom_range(9)];
      return BYTE_W'($urandom_range(254));
   endfunction

   task automatic push_random_frame(int phase);
      int pick;
      if ($urandom_range(99) < 8) begin
         // stray bytes while waiting for a start byte
         repeat ($urandom_range(1, 3)) push_byte(BYTE_W'($urandom_range(253)), phase);
         return;
      end
      push_byte(START_BYTE, phase);
      repeat (PARAM_COUNT) push_byte(pick_param(), phase);
      pick = $urandom_range(99);
      if (pick < 85)
         push_byte(STOP_BYTE, phase);
      else if (pick < 93)
         push_byte(START_BYTE, phase);
      else
         push_byte(BYTE_W'($urandom_range(255)), phase);
      frame_bytes += PARAM_COUNT + 2;
   endtask

   task automatic push_directed(logic [BYTE_W-1:0] bytes[]);
      foreach (bytes[i]) push_byte(bytes[i], 0);
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   // driver: one beat in flight, payload held while stalled
   always @(posedge clock) begin : driver
      rx_beat_type nxt;
      bit          send;
      if (reset) begin
         req_valid <= 1'b0;
         frame_pos = POS_IDLE;
         partial_params = '0;
      end else begin
         if (req_valid && !req_stall)
            take_rx_byte(req_rx_byte);
         if (!req_valid || !req_stall) begin
            send = 1'b0;
            if (rx_beats.size() != 0 && rx_beats[0].drain && pending_drives.size() == 0)
               void'(rx_beats.pop_front());
            if (rx_beats.size() != 0 && !rx_beats[0].drain &&
                $urandom_range(99) >= sender_idle_pct(rx_beats[0].phase)) begin
               nxt = rx_beats.pop_front();
               send = 1'b1;
               traffic_phase <= nxt.phase;
               req_rx_byte <= nxt.rx_byte;
            end
            req_valid <= send;
         end
      end
   end

   always @(posedge clock) begin : monitor
      drive_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            drives_seen++;
            if (pending_drives.size() == 0) begin
               report_mismatch("result with nothing pending", 1, 0);
            end else begin
               want = pending_drives.pop_front();
               check_field("param_one", rsp_param_one, want.params[0]);
               check_field("param_two", rsp_param_two, want.params[1]);
               check_field("param_three", rsp_param_three, want.params[2]);
               check_field("param_four", rsp_param_four, want.params[3]);
               check_field("param_five", rsp_param_five, want.params[4]);
               check_field("left_forward", rsp_left_forward, want.left_forward);
               check_field("left_duty", rsp_left_duty, want.left_duty);
               check_field("right_forward", rsp_right_forward, want.right_forward);
               check_field("right_duty", rsp_right_duty, want.right_duty);
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct(traffic_phase));
      end
   end

   initial begin
      // plain frames at both ends of the axes, then restarts and discarded frames
      push_directed('{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd254});
      push_directed('{8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254});
      push_directed('{8'd3, 8'd255, 8'd9, 8'd255, 8'd128, 8'd127, 8'd126, 8'd125, 8'd100,
                      8'd255, 8'd85, 8'd170, 8'd40, 8'd240, 8'd15, 8'd17});
      for (int phase = 0; phase < 3; phase++) begin
         while (frame_bytes < (phase + 1) * FRAME_BYTES / 3)
            push_random_frame(phase);
         push_drain(phase);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (rx_beats.size() != 0 || req_valid || pending_drives.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_drives.size() != 0)
         report_mismatch("results still pending", pending_drives.size(), 0);

      if (mismatch_count == 0)
         $display("[joystick_frame_differential_drive_unit] OK");
      else
         $display("[joystick_frame_differential_drive_unit] ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[joystick_frame_differential_drive_unit] ERROR");
      $finish;
   end

endmodule
